// ----- rtl/shared_pool_multi_queue_manager_macros.svh -----
// Assertion macros for the shared pool multi-queue manager.
// Expects clk and rst in the scope of each use.
`ifndef SHARED_POOL_MULTI_QUEUE_MANAGER_MACROS_SVH
`define SHARED_POOL_MULTI_QUEUE_MANAGER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SPMQM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spmqm: same-cycle check failed");

// Next-cycle implication, off during reset.
`define SPMQM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spmqm: next-cycle check failed");

`endif

// ----- rtl/spmqm_pkg.sv -----
// Package for the shared pool multi-queue manager: sizes, command and
// status codes, and the queue descriptor type. No dependencies.
`timescale 1ns / 1ps

package spmqm_pkg;

  localparam int NUM_QUEUES = 32;
  localparam int NUM_NODES  = 128;
  localparam int MSG_WIDTH  = 32;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 5;
  localparam int CAP_W   = 8;
  localparam int MSG_IO_W = 32;
  localparam int STAT_W  = 3;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int AW = $clog2(NUM_NODES);
  localparam int NW = $clog2(NUM_NODES + 1);

  localparam logic [NW-1:0] NODE_NULL = NW'(NUM_NODES);

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_QUEUE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 3'd5;

  typedef struct packed {
    logic [NW-1:0]    head;
    logic [NW-1:0]    tail;
    logic [CAP_W-1:0] count;
    logic [CAP_W-1:0] limit;
  } qrec_t;

endpackage

// ----- rtl/shared_pool_multi_queue_manager.sv -----
// Shared pool multi-queue manager: FIFO queues over one linked node pool.
// Depends on spmqm_pkg and shared_pool_multi_queue_manager_macros.svh.
//
//   channel | handshake             | beat
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_stall   | command, queue_id, capacity, message
//   out     | out_valid / out_stall | status, queue_handle, message_out
//
// Steps per command from accept to result: delete and decode errors pass decode
// and finish; read passes decode, node and finish; write adds a second link
// write to the single-port link memory when the queue was not empty; create
// searches the single-port queue table one slot per cycle, up to NUM_QUEUES.
// Reset is synchronous; the link memory reads its chained reset value through
// per-node valid bits, so no clearing pass is needed.
// in_stall is high while a command is in progress; a finished result waits in
// the output register under out_stall while the next command is accepted.
`timescale 1ns / 1ps
`include "shared_pool_multi_queue_manager_macros.svh"

module shared_pool_multi_queue_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spmqm_pkg::CMD_W-1:0]   command,
  input  logic [spmqm_pkg::ID_W-1:0]    queue_id,
  input  logic [spmqm_pkg::CAP_W-1:0]   capacity,
  input  logic [spmqm_pkg::MSG_IO_W-1:0] message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spmqm_pkg::STAT_W-1:0]  status,
  output logic [spmqm_pkg::ID_W-1:0]    queue_handle,
  output logic [spmqm_pkg::MSG_IO_W-1:0] message_out
);
  import spmqm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_NODE   = 3'd3;
  localparam logic [2:0] S_LINK2  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]           state;
  logic [CMD_W-1:0]     cmd_r;
  logic [ID_W-1:0]      qid_r;
  logic [CAP_W-1:0]     cap_r;
  logic [MSG_IO_W-1:0]  msg_r;
  logic [QW-1:0]        p;
  logic [QW-1:0]        search_start;
  logic [NW-1:0]        free_head;
  logic [NW-1:0]        node_r;
  logic [NUM_QUEUES-1:0] alloc;
  logic [NUM_NODES-1:0] link_vld;
  logic [STAT_W-1:0]    res_status;
  logic [ID_W-1:0]      res_handle;
  logic [MSG_IO_W-1:0]  res_msg;

  qrec_t                qmem [NUM_QUEUES];
  logic [NW-1:0]        link_mem [NUM_NODES];
  logic [MSG_WIDTH-1:0] pay_mem [NUM_NODES];

  qrec_t                qrec_q;
  logic [NW-1:0]        link_q;
  logic                 link_vld_q;
  logic [AW-1:0]        link_addr_q;
  logic [MSG_WIDTH-1:0] pay_q;

  logic                 q_we;
  logic [QW-1:0]        q_waddr;
  qrec_t                q_wdata;
  logic                 l_we;
  logic [AW-1:0]        l_waddr;
  logic [NW-1:0]        l_wdata;
  logic [AW-1:0]        l_raddr;
  logic                 p_we;

  logic [NW-1:0]        link_rd;
  logic [QW-1:0]        prev_p;
  logic                 search_hit;
  logic                 handle_ok;
  logic                 head_ok;
  logic                 tail_ok;
  logic                 q_empty;
  logic                 q_full;
  logic                 pool_dry;
  logic                 fin_go;

  assign in_stall   = (state != S_IDLE);
  assign link_rd    = link_vld_q ? link_q : NW'(link_addr_q) + NW'(1);
  assign prev_p     = (p == '0) ? QW'(NUM_QUEUES - 1) : p - QW'(1);
  assign search_hit = !alloc[p];
  assign handle_ok  = (int'(qid_r) < NUM_QUEUES) && alloc[qid_r[QW-1:0]];
  assign head_ok    = (qrec_q.head != NODE_NULL);
  assign tail_ok    = (qrec_q.tail != NODE_NULL);
  assign q_empty    = (qrec_q.count == '0) || !head_ok;
  assign q_full     = (qrec_q.count >= qrec_q.limit);
  assign pool_dry   = (free_head == NODE_NULL);
  assign fin_go     = !out_valid || !out_stall;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = qid_r[QW-1:0];
    q_wdata = qrec_q;
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = free_head;
    l_raddr = '0;
    p_we    = 1'b0;
    unique case (state)
      S_SEARCH: begin
        if (search_hit) begin
          q_we    = 1'b1;
          q_waddr = p;
          q_wdata = '{head: NODE_NULL, tail: NODE_NULL, count: '0, limit: cap_r};
        end
      end
      S_DECODE: begin
        l_raddr = (cmd_r == CMD_READ) ? qrec_q.head[AW-1:0] : free_head[AW-1:0];
        if (handle_ok && cmd_r == CMD_DELETE && head_ok && tail_ok) begin
          l_we    = 1'b1;
          l_waddr = qrec_q.tail[AW-1:0];
          l_wdata = free_head;
        end
      end
      S_NODE: begin
        q_we = 1'b1;
        if (cmd_r == CMD_READ) begin
          q_wdata.count = qrec_q.count - CAP_W'(1);
          if (qrec_q.head == qrec_q.tail) begin
            q_wdata.head = NODE_NULL;
            q_wdata.tail = NODE_NULL;
          end else begin
            q_wdata.head = link_rd;
          end
          l_we    = 1'b1;
          l_waddr = qrec_q.head[AW-1:0];
          l_wdata = free_head;
        end else begin
          q_wdata.count = qrec_q.count + CAP_W'(1);
          q_wdata.head  = tail_ok ? qrec_q.head : free_head;
          q_wdata.tail  = free_head;
          l_we    = 1'b1;
          l_waddr = free_head[AW-1:0];
          l_wdata = NODE_NULL;
          p_we    = 1'b1;
        end
      end
      S_LINK2: begin
        l_we    = 1'b1;
        l_waddr = qrec_q.tail[AW-1:0];
        l_wdata = node_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      qrec_q <= qmem[queue_id[QW-1:0]];
    end
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    link_q      <= link_mem[l_raddr];
    link_addr_q <= l_raddr;
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld   <= '0;
      link_vld_q <= 1'b0;
    end else begin
      link_vld_q <= link_vld[l_raddr];
      if (l_we) begin
        link_vld[l_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pay_q <= pay_mem[qrec_q.head[AW-1:0]];
    if (p_we) begin
      pay_mem[free_head[AW-1:0]] <= MSG_WIDTH'(msg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      search_start <= QW'(NUM_QUEUES - 1);
      free_head    <= '0;
      alloc        <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= command;
            qid_r <= queue_id;
            cap_r <= capacity;
            msg_r <= message;
            p     <= search_start;
            state <= (command == CMD_CREATE) ? S_SEARCH : S_DECODE;
          end
        end
        S_SEARCH: begin
          res_msg <= '0;
          if (search_hit) begin
            alloc[p]     <= 1'b1;
            search_start <= prev_p;
            res_status   <= ST_OK;
            res_handle   <= ID_W'(p);
            state        <= S_FIN;
          end else if (prev_p == search_start) begin
            res_status <= ST_NO_QUEUE;
            res_handle <= '0;
            state      <= S_FIN;
          end else begin
            p <= prev_p;
          end
        end
        S_DECODE: begin
          res_msg    <= '0;
          res_handle <= '0;
          if (!handle_ok) begin
            res_status <= ST_BAD_HANDLE;
            state      <= S_FIN;
          end else begin
            unique case (cmd_r)
              CMD_DELETE: begin
                alloc[qid_r[QW-1:0]] <= 1'b0;
                if (head_ok && tail_ok) begin
                  free_head <= qrec_q.head;
                end
                res_status <= ST_OK;
                state      <= S_FIN;
              end
              CMD_READ: begin
                if (q_empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_NODE;
                end
              end
              CMD_WRITE: begin
                if (q_full) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else if (pool_dry) begin
                  res_status <= ST_EXHAUSTED;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  node_r     <= free_head;
                  state      <= S_NODE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_NODE: begin
          if (cmd_r == CMD_READ) begin
            res_msg   <= MSG_IO_W'(pay_q);
            free_head <= qrec_q.head;
            state     <= S_FIN;
          end else begin
            free_head <= link_rd;
            state     <= tail_ok ? S_LINK2 : S_FIN;
          end
        end
        S_LINK2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            status       <= res_status;
            queue_handle <= res_handle;
            message_out  <= res_msg;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPMQM_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `SPMQM_ASSERT_NOW(a_write_has_node, state == S_NODE && cmd_r == CMD_WRITE,
                    free_head != NODE_NULL)
  `SPMQM_ASSERT_NOW(a_create_alloc,
                    state == S_FIN && cmd_r == CMD_CREATE && res_status == ST_OK,
                    alloc[res_handle[QW-1:0]])

endmodule
